/* rtl/maeom_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// maeom_pkg
// Shared types, constants and calendar helpers for the month adder with
// end-of-month snapping.
// ----------------------------------------------------------------------------
package maeom_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int CNT_W   = 12;
	localparam int R400_W  = 9;
	localparam int Q400_W  = 6;

	localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
	localparam logic [CNT_W-1:0]   MAX_MONTHS = 12'd4095;
	localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
	localparam logic [R400_W-1:0]  R400_LAST  = 9'd399;

	// year / 400 as (year * DIV400_MUL) >> DIV400_SHIFT, exact for 14-bit years
	localparam int DIV400_SHIFT = 21;
	localparam int PROD_W       = YEAR_W + 13;
	localparam logic [12:0] DIV400_MUL = 13'd5243;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_REM,
		S_CHECK,
		S_STEP,
		S_DONE
	} state_t;

	// leap test on year mod 400: divisible by 4 but not a non-400 century
	function automatic logic is_leap400(input logic [R400_W-1:0] r);
		is_leap400 = (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] n;
		unique case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			MONTH_FEB:               n = leap ? 5'd29 : 5'd28;
			default:                 n = 5'd31;
		endcase
		month_len = n;
	endfunction

endpackage
`default_nettype wire

/* rtl/maeom_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// maeom_if
// Valid/ready channels for the month adder: date request and date result.
// ----------------------------------------------------------------------------
interface maeom_in_if;
	logic        valid;
	logic        ready;
	logic [13:0] start_year;
	logic [3:0]  start_month;
	logic [4:0]  start_day;
	logic [11:0] months_to_add;

	modport source (output valid, output start_year, output start_month,
		output start_day, output months_to_add, input ready);
	modport sink (input valid, input start_year, input start_month,
		input start_day, input months_to_add, output ready);
endinterface

interface maeom_out_if;
	logic        valid;
	logic        ready;
	logic [13:0] result_year;
	logic [3:0]  result_month;
	logic [4:0]  result_day;
	logic        date_error;

	modport source (output valid, output result_year, output result_month,
		output result_day, output date_error, input ready);
	modport sink (input valid, input result_year, input result_month,
		input result_day, input date_error, output ready);
endinterface
`default_nettype wire

/* rtl/maeom_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// maeom_step
// One month step: advances month and year, tracks year mod 400 and snaps or
// clamps the day to the length of the target month.
// ----------------------------------------------------------------------------
module maeom_step (
	input  maeom_pkg::date_t                     cur,
	input  logic [maeom_pkg::R400_W-1:0]         yr400,
	output maeom_pkg::date_t                     nxt,
	output logic [maeom_pkg::R400_W-1:0]         nxt_yr400,
	output logic                                 ovf
);

	logic                           at_end;
	logic [maeom_pkg::DAY_W-1:0]    len;

	always_comb begin
		at_end = (cur.day == maeom_pkg::month_len(cur.month, maeom_pkg::is_leap400(yr400)));
		if (cur.month == maeom_pkg::MONTH_DEC) begin
			nxt.month = maeom_pkg::MONTH_JAN;
			nxt.year  = cur.year + 14'd1;
			nxt_yr400 = (yr400 == maeom_pkg::R400_LAST) ? 9'd0 : yr400 + 9'd1;
			ovf       = (cur.year >= maeom_pkg::YEAR_MAX);
		end else begin
			nxt.month = cur.month + 4'd1;
			nxt.year  = cur.year;
			nxt_yr400 = yr400;
			ovf       = 1'b0;
		end
		len = maeom_pkg::month_len(nxt.month, maeom_pkg::is_leap400(nxt_yr400));
		// last day stays last day; a day past the new month end clamps
		nxt.day = (at_end || (cur.day > len)) ? len : cur.day;
	end

endmodule
`default_nettype wire

/* rtl/month_add_end_of_month_snap.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// month_add_end_of_month_snap
// Adds a month count to a Gregorian date with end-of-month snapping.
// ----------------------------------------------------------------------------
// A request word is taken while the block is idle. The month steps taken are
// months_to_add (0..4095) for a valid date, none for an invalid date, and up to
// the overflowing step when the year passes 9999. The setup states S_DIV, S_REM
// and S_CHECK find the start year mod 400 and check the date, then the single
// month-step unit applies one month per cycle, and S_DONE loads the result
// word into the output register when the output is free. A result waiting on
// the output does not block the next request word; a new word is held off
// while the block is busy with a word, also while a result cannot be
// unloaded.
// An invalid start date or a year past 9999 gives date_error with zero fields.
module month_add_end_of_month_snap (
	input  logic          clk,
	input  logic          arst_n,
	maeom_in_if.sink      req,
	maeom_out_if.source   rsp
);

	maeom_pkg::state_t                   state_q, state_d;
	maeom_pkg::date_t                    date_q;
	maeom_pkg::date_t                    step_nxt;
	logic [maeom_pkg::CNT_W-1:0]         cnt_q;
	logic [maeom_pkg::Q400_W-1:0]        q400_q;
	logic [maeom_pkg::R400_W-1:0]        yr400_q;
	logic [maeom_pkg::R400_W-1:0]        step_yr400;
	logic                                step_ovf;
	logic                                err_q;
	logic [maeom_pkg::PROD_W-1:0]        prod;
	logic                                bad_date;

	logic                                rsp_valid_q;
	logic [13:0]                         rsp_year_q;
	logic [3:0]                          rsp_month_q;
	logic [4:0]                          rsp_day_q;
	logic                                rsp_err_q;

	logic ld_in, ld_q, ld_r, do_step, set_err, ld_out;

	maeom_step u_step (
		.cur       (date_q),
		.yr400     (yr400_q),
		.nxt       (step_nxt),
		.nxt_yr400 (step_yr400),
		.ovf       (step_ovf)
	);

	assign prod = maeom_pkg::PROD_W'(date_q.year) * maeom_pkg::PROD_W'(maeom_pkg::DIV400_MUL);

	always_comb begin
		bad_date = (date_q.year == 14'd0) || (date_q.year > maeom_pkg::YEAR_MAX) ||
			(date_q.month == 4'd0) || (date_q.month > maeom_pkg::MONTH_DEC) ||
			(date_q.day == 5'd0) ||
			(date_q.day > maeom_pkg::month_len(date_q.month, maeom_pkg::is_leap400(yr400_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= maeom_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		ld_in     = 1'b0;
		ld_q      = 1'b0;
		ld_r      = 1'b0;
		do_step   = 1'b0;
		set_err   = 1'b0;
		ld_out    = 1'b0;
		unique case (state_q)
			maeom_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					ld_in   = 1'b1;
					state_d = maeom_pkg::S_DIV;
				end
			end
			maeom_pkg::S_DIV: begin
				ld_q    = 1'b1;
				state_d = maeom_pkg::S_REM;
			end
			maeom_pkg::S_REM: begin
				ld_r    = 1'b1;
				state_d = maeom_pkg::S_CHECK;
			end
			maeom_pkg::S_CHECK: begin
				if (bad_date) begin
					set_err = 1'b1;
					state_d = maeom_pkg::S_DONE;
				end else if (cnt_q == '0) begin
					state_d = maeom_pkg::S_DONE;
				end else begin
					state_d = maeom_pkg::S_STEP;
				end
			end
			maeom_pkg::S_STEP: begin
				if (step_ovf) begin
					set_err = 1'b1;
					state_d = maeom_pkg::S_DONE;
				end else begin
					do_step = 1'b1;
					if (cnt_q == 12'd1) begin
						state_d = maeom_pkg::S_DONE;
					end
				end
			end
			maeom_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					ld_out  = 1'b1;
					state_d = maeom_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = maeom_pkg::S_IDLE;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ld_in) begin
			date_q.year  <= req.start_year;
			date_q.month <= req.start_month;
			date_q.day   <= req.start_day;
			cnt_q        <= (req.months_to_add > maeom_pkg::MAX_MONTHS) ?
				maeom_pkg::MAX_MONTHS : req.months_to_add;
		end
		if (ld_q) begin
			q400_q <= prod[maeom_pkg::DIV400_SHIFT +: maeom_pkg::Q400_W];
		end
		if (ld_r) begin
			yr400_q <= maeom_pkg::R400_W'(15'(date_q.year) - 15'(q400_q) * 15'd400);
		end
		if (do_step) begin
			date_q  <= step_nxt;
			yr400_q <= step_yr400;
			cnt_q   <= cnt_q - 12'd1;
		end
		if (ld_out) begin
			rsp_year_q  <= err_q ? 14'd0 : date_q.year;
			rsp_month_q <= err_q ? 4'd0  : date_q.month;
			rsp_day_q   <= err_q ? 5'd0  : date_q.day;
			rsp_err_q   <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ld_in) begin
				err_q <= 1'b0;
			end else if (set_err) begin
				err_q <= 1'b1;
			end
			if (ld_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_year  = rsp_year_q;
	assign rsp.result_month = rsp_month_q;
	assign rsp.result_day   = rsp_day_q;
	assign rsp.date_error   = rsp_err_q;

endmodule
`default_nettype wire

/* rtl/maeom_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// maeom_chk
// Port-level checks for the month adder, bound to the top level.
// ----------------------------------------------------------------------------
module maeom_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [13:0] result_year,
	input logic [3:0]  result_month,
	input logic [4:0]  result_day,
	input logic        date_error
);

	// stalled result word is held
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_year) &&
		$stable(result_month) && $stable(result_day) && $stable(date_error))
		else $error("result word changed while stalled");

	// one item at a time: busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous item in flight");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && date_error |->
		(result_year == 14'd0) && (result_month == 4'd0) && (result_day == 5'd0))
		else $error("error result with nonzero date");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !date_error |->
		(result_year != 14'd0) && (result_year <= maeom_pkg::YEAR_MAX) &&
		(result_month != 4'd0) && (result_month <= maeom_pkg::MONTH_DEC) &&
		(result_day != 5'd0))
		else $error("valid result date out of range");

endmodule

bind month_add_end_of_month_snap maeom_chk u_maeom_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.result_year  (rsp.result_year),
	.result_month (rsp.result_month),
	.result_day   (rsp.result_day),
	.date_error   (rsp.date_error)
);
`default_nettype wire
